// ----- design/hpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hpm_pkg - shared types and constants of the handshake protocol monitor
// Register map, result kinds, handshake sample codes, beat bundles and
// saturating counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

   // lane geometry
   localparam int LANES       = 4;   // lanes held at stall start (1..8)
   localparam int LANE_BITS   = 32;  // compared value bits per lane (1..32)
   localparam int INPUT_LANES = 4;   // lanes carried by one input beat
   localparam int MAX_OUT     = 4;   // result slots per input beat
   localparam int USED_LANES  = (LANES < INPUT_LANES) ? LANES : INPUT_LANES;

   localparam logic [31:0] HALF_MASK = 32'hFFFF_FFFF >> (32 - LANE_BITS);
   localparam logic [63:0] LANE_MASK = {HALF_MASK, HALF_MASK};

   // register map (index = paddr[3:2])
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_MAX_WAIT      = 2'd0;
   localparam logic [1:0] REG_CHECK_DATA    = 2'd1;
   localparam logic [1:0] REG_FINDING_LIMIT = 2'd2;
   localparam logic [1:0] REG_DATA_LANES    = 2'd3;

   localparam logic [15:0] MAX_WAIT_RST      = 16'd100;
   localparam logic        CHECK_DATA_RST    = 1'b0;
   localparam logic [16:0] FINDING_LIMIT_RST = 17'd100;
   localparam logic [2:0]  DATA_LANES_RST    = 3'd0;

   // handshake sample codes
   localparam logic [1:0] HS_FALSE = 2'd0;
   localparam logic [1:0] HS_TRUE  = 2'd1;

   // input beat operations
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_END    = 1'b1;

   typedef enum logic [1:0] {
      KIND_READY_ONLY   = 2'd0,
      KIND_DATA_CHANGED = 2'd1,
      KIND_LONG_STALL   = 2'd2,
      KIND_SUMMARY      = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] wait_limit;
      logic        data_check_en;
      logic [16:0] report_cap;
      logic [2:0]  data_lanes;
   } cfg_type;

   typedef struct packed {
      logic                              op;
      logic [63:0]                       stamp;
      logic [1:0]                        valid_state;
      logic [1:0]                        ready_state;
      logic [INPUT_LANES-1:0][63:0]      lanes;
   } item_type;

   // everything one input beat leaves for the result side
   typedef struct packed {
      logic [MAX_OUT-1:0]                slots;
      kind_type [MAX_OUT-1:0]            kinds;
      logic                              open_at_end;
      logic [63:0]                       begin_time;
      logic [63:0]                       at_time;
      logic [31:0]                       stall_len;
      logic [31:0]                       longest;
      logic [31:0]                       samples_total;
      logic [31:0]                       transfer_count;
      logic [31:0]                       ready_only_count;
      logic [31:0]                       violation_count;
      logic [31:0]                       findings_total;
   } result_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add32(input logic [31:0] x, input logic [2:0] d);
      logic [32:0] sum;
      sum = {1'b0, x} + {30'd0, d};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/handshake_protocol_monitor.sv -----
// ----------------------------------------------------------------------------
// handshake_protocol_monitor - valid/ready handshake protocol checker
// Path: an input beat is held in the core's input register, then loaded into
//   the result bank, which offers its first result beat.
// Throughput: 1 input beat per cycle while each beat yields at most one
//   result and rsp_stall is low; a beat with more results holds the input until
//   the single result port drains the bank, one beat per cycle without rsp_stall.
// Reset (synchronous): counters, stall tracker and result bank clear; the
//   stall wait limit returns to 100, the data check to off, the finding cap
//   to 100 and the lane count to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module handshake_protocol_monitor (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration port
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [hpm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   // input beats: clock samples and window-end markers
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_op,
   input  wire logic [63:0]                req_sample_time,
   input  wire logic [1:0]                 req_valid_state,
   input  wire logic [1:0]                 req_ready_state,
   input  wire logic [63:0]                req_lane0,
   input  wire logic [63:0]                req_lane1,
   input  wire logic [63:0]                req_lane2,
   input  wire logic [63:0]                req_lane3,
   // result beats: findings and window summaries
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [63:0]                     rsp_begin_time,
   output logic [63:0]                     rsp_at_time,
   output logic [31:0]                     rsp_cycles,
   output logic [1:0]                      rsp_lane,
   output logic                            rsp_open_at_end,
   output logic                            rsp_last,
   output logic [31:0]                     rsp_sample_count,
   output logic [31:0]                     rsp_transfer_count,
   output logic [31:0]                     rsp_ready_only_count,
   output logic [31:0]                     rsp_violation_count,
   output logic [31:0]                     rsp_finding_count
);

   hpm_pkg::cfg_type    cfg;
   hpm_pkg::item_type   req_item;
   hpm_pkg::result_type res;
   logic                res_load;
   logic                bank_free;

   // bundle the input beat; lanes go in lane order
   assign req_item.op          = req_op;
   assign req_item.stamp       = req_sample_time;
   assign req_item.valid_state = req_valid_state;
   assign req_item.ready_state = req_ready_state;
   assign req_item.lanes[0]    = req_lane0;
   assign req_item.lanes[1]    = req_lane1;
   assign req_item.lanes[2]    = req_lane2;
   assign req_item.lanes[3]    = req_lane3;

   // registers: the user must write them only while the monitor is idle; the block does not enforce it
   hpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register and monitor state: one pass per beat, and the beat
   // advances only when the result bank can take all its findings
   hpm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .bank_free (bank_free),
      .res_load  (res_load),
      .res       (res)
   );

   // result bank: drain lowest slot first, flag the final beat of each input
   hpm_rsp u_rsp (
      .clock                (clock),
      .reset                (reset),
      .res_load             (res_load),
      .res                  (res),
      .bank_free            (bank_free),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_begin_time       (rsp_begin_time),
      .rsp_at_time          (rsp_at_time),
      .rsp_cycles           (rsp_cycles),
      .rsp_lane             (rsp_lane),
      .rsp_open_at_end      (rsp_open_at_end),
      .rsp_last             (rsp_last),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_transfer_count   (rsp_transfer_count),
      .rsp_ready_only_count (rsp_ready_only_count),
      .rsp_violation_count  (rsp_violation_count),
      .rsp_finding_count    (rsp_finding_count)
   );

endmodule

`default_nettype wire

// ----- design/hpm_csr.sv -----
// ----------------------------------------------------------------------------
// hpm_csr - configuration registers
// APB-style register file; writes land in the access phase, reads return
// the stored register pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [hpm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output hpm_pkg::cfg_type                cfg
);

   hpm_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_limit    <= hpm_pkg::MAX_WAIT_RST;
         cfg_ff.data_check_en <= hpm_pkg::CHECK_DATA_RST;
         cfg_ff.report_cap    <= hpm_pkg::FINDING_LIMIT_RST;
         cfg_ff.data_lanes    <= hpm_pkg::DATA_LANES_RST;
      end else if (wr_en) begin
         case (reg_idx)
            hpm_pkg::REG_MAX_WAIT:      cfg_ff.wait_limit    <= pwdata[15:0];
            hpm_pkg::REG_CHECK_DATA:    cfg_ff.data_check_en <= pwdata[0];
            hpm_pkg::REG_FINDING_LIMIT: cfg_ff.report_cap    <= pwdata[16:0];
            hpm_pkg::REG_DATA_LANES:    cfg_ff.data_lanes    <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         hpm_pkg::REG_MAX_WAIT:      prdata = {16'd0, cfg_ff.wait_limit};
         hpm_pkg::REG_CHECK_DATA:    prdata = {31'd0, cfg_ff.data_check_en};
         hpm_pkg::REG_FINDING_LIMIT: prdata = {15'd0, cfg_ff.report_cap};
         hpm_pkg::REG_DATA_LANES:    prdata = {29'd0, cfg_ff.data_lanes};
         default:                    prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/hpm_core.sv -----
// ----------------------------------------------------------------------------
// hpm_core - input register, monitor state and finding generation
// Holds one input beat, updates the stall tracker and counters in a single
// pass, and hands the findings of the beat to the result bank.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hpm_pkg::cfg_type  cfg,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hpm_pkg::item_type req_item,
   input  wire logic              bank_free,
   output logic                   res_load,
   output hpm_pkg::result_type    res
);

   localparam logic [2:0] USED_LANES_C = 3'(hpm_pkg::USED_LANES);

   logic              item_valid_ff, item_valid_in;
   hpm_pkg::item_type item_ff;

   logic        in_stall_ff, in_stall_in;
   logic [31:0] stall_length_ff, stall_length_in;
   logic [63:0] stall_start_ff;
   logic [hpm_pkg::USED_LANES-1:0][63:0] stall_lanes_ff;
   logic [31:0] samples_ff, samples_in;
   logic [31:0] transfers_ff, transfers_in;
   logic [31:0] longest_ff, longest_in;
   logic [31:0] ready_only_ff, ready_only_in;
   logic [31:0] violations_ff, violations_in;
   logic [31:0] findings_ff, findings_in;

   logic        fire, take;
   logic        is_end, vt, vf, rt, rf, stall_beat, ready_alone, end_stall, overlong;
   logic        capture;
   logic [2:0]  lanes_n;
   logic [hpm_pkg::MAX_OUT-1:0] differ, find;
   logic [2:0]  prefix;
   logic [33:0] seen_sum;
   logic        limit_ok;
   logic [31:0] longest_upd;

   assign fire      = item_valid_ff & bank_free;
   assign req_stall = item_valid_ff & ~bank_free;
   assign take      = req_valid & ~req_stall;
   assign res_load  = fire;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (take) begin
         item_ff <= req_item;
      end
   end

   // decode the sample
   assign is_end      = (item_ff.op == hpm_pkg::OP_END);
   assign vt          = (item_ff.valid_state == hpm_pkg::HS_TRUE);
   assign vf          = (item_ff.valid_state == hpm_pkg::HS_FALSE);
   assign rt          = (item_ff.ready_state == hpm_pkg::HS_TRUE);
   assign rf          = (item_ff.ready_state == hpm_pkg::HS_FALSE);
   assign stall_beat  = ~is_end & vt & rf;
   assign ready_alone = ~is_end & rt & vf;
   assign end_stall   = in_stall_ff & (is_end | ~stall_beat);
   assign overlong    = end_stall & (stall_length_ff > {16'd0, cfg.wait_limit});
   assign capture     = stall_beat & ~in_stall_ff;
   assign lanes_n     = (cfg.data_lanes > USED_LANES_C) ? USED_LANES_C : cfg.data_lanes;
   assign longest_upd = (end_stall && stall_length_ff > longest_ff) ? stall_length_ff
                                                                     : longest_ff;

   always_comb begin
      for (int i = 0; i < hpm_pkg::MAX_OUT; i++) begin
         differ[i] = 1'b0;
         if (i < hpm_pkg::USED_LANES) begin
            differ[i] = stall_beat & in_stall_ff & cfg.data_check_en & (3'(i) < lanes_n) &
                        (|((item_ff.lanes[i] ^ stall_lanes_ff[i]) & hpm_pkg::LANE_MASK));
         end
      end
   end

   // slot layout: sample -> lane findings in lane order, or ready-only then
   // long stall; window end -> long stall then summary
   always_comb begin
      find = differ;
      if (is_end) begin
         find    = '0;
         find[0] = overlong;
      end else if (!stall_beat) begin
         find    = '0;
         find[0] = ready_alone;
         find[1] = overlong;
      end
   end

   always_comb begin
      res        = '0;
      prefix     = 3'd0;
      seen_sum   = '0;
      limit_ok   = 1'b0;
      for (int s = 0; s < hpm_pkg::MAX_OUT; s++) begin
         seen_sum = {2'b00, findings_ff} + {31'd0, prefix};
         limit_ok = cfg.report_cap[16] | (seen_sum < {18'd0, cfg.report_cap[15:0]});
         res.slots[s] = find[s] & limit_ok;
         res.kinds[s] = hpm_pkg::KIND_DATA_CHANGED;
         prefix       = prefix + {2'b00, find[s]};
      end
      if (is_end) begin
         res.kinds[0] = hpm_pkg::KIND_LONG_STALL;
         res.kinds[1] = hpm_pkg::KIND_SUMMARY;
         res.slots[1] = 1'b1;
      end else if (!stall_beat) begin
         res.kinds[0] = hpm_pkg::KIND_READY_ONLY;
         res.kinds[1] = hpm_pkg::KIND_LONG_STALL;
      end
      res.open_at_end      = is_end;
      res.begin_time       = stall_start_ff;
      res.at_time          = item_ff.stamp;
      res.stall_len        = stall_length_ff;
      res.longest          = longest_upd;
      res.samples_total    = samples_ff;
      res.transfer_count   = transfers_ff;
      res.ready_only_count = ready_only_ff;
      res.violation_count  = violations_ff;
      res.findings_total   = findings_in;
   end

   // next state
   always_comb begin
      findings_in   = hpm_pkg::sat_add32(findings_ff, 3'($countones(find)));
      violations_in = hpm_pkg::sat_add32(violations_ff, 3'($countones(differ)));
      samples_in    = hpm_pkg::sat_inc32(samples_ff);
      transfers_in  = (vt & rt) ? hpm_pkg::sat_inc32(transfers_ff) : transfers_ff;
      ready_only_in = ready_alone ? hpm_pkg::sat_inc32(ready_only_ff) : ready_only_ff;
      longest_in    = longest_upd;
      in_stall_in     = in_stall_ff;
      stall_length_in = stall_length_ff;
      if (stall_beat) begin
         in_stall_in     = 1'b1;
         stall_length_in = hpm_pkg::sat_inc32(stall_length_ff);
      end else if (in_stall_ff) begin
         in_stall_in     = 1'b0;
         stall_length_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_stall_ff     <= 1'b0;
         stall_length_ff <= 32'd0;
         samples_ff      <= 32'd0;
         transfers_ff    <= 32'd0;
         longest_ff      <= 32'd0;
         ready_only_ff   <= 32'd0;
         violations_ff   <= 32'd0;
         findings_ff     <= 32'd0;
      end else if (fire) begin
         if (is_end) begin
            in_stall_ff     <= 1'b0;
            stall_length_ff <= 32'd0;
            samples_ff      <= 32'd0;
            transfers_ff    <= 32'd0;
            longest_ff      <= 32'd0;
            ready_only_ff   <= 32'd0;
            violations_ff   <= 32'd0;
            findings_ff     <= 32'd0;
         end else begin
            in_stall_ff     <= in_stall_in;
            stall_length_ff <= stall_length_in;
            samples_ff      <= samples_in;
            transfers_ff    <= transfers_in;
            longest_ff      <= longest_in;
            ready_only_ff   <= ready_only_in;
            violations_ff   <= violations_in;
            findings_ff     <= findings_in;
         end
      end
   end

   // stall snapshot is only read while a stall is open
   always_ff @(posedge clock) begin
      if (fire && capture) begin
         stall_start_ff <= item_ff.stamp;
         for (int i = 0; i < hpm_pkg::USED_LANES; i++) begin
            stall_lanes_ff[i] <= item_ff.lanes[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/hpm_rsp.sv -----
// ----------------------------------------------------------------------------
// hpm_rsp - result bank
// Holds the findings of one input beat in fixed slots and sends them out
// lowest slot first, one beat per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_rsp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                res_load,
   input  wire hpm_pkg::result_type res,
   output logic                     bank_free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [63:0]              rsp_begin_time,
   output logic [63:0]              rsp_at_time,
   output logic [31:0]              rsp_cycles,
   output logic [1:0]               rsp_lane,
   output logic                     rsp_open_at_end,
   output logic                     rsp_last,
   output logic [31:0]              rsp_sample_count,
   output logic [31:0]              rsp_transfer_count,
   output logic [31:0]              rsp_ready_only_count,
   output logic [31:0]              rsp_violation_count,
   output logic [31:0]              rsp_finding_count
);

   logic [hpm_pkg::MAX_OUT-1:0] slots_ff, slots_in;
   hpm_pkg::result_type         res_ff;
   logic [hpm_pkg::MAX_OUT-1:0] head;
   logic [1:0]                  head_idx;
   hpm_pkg::kind_type           kind;
   logic                        pop;

   assign head      = slots_ff & (~slots_ff + 1'b1);
   assign rsp_valid = |slots_ff;
   assign rsp_last  = ((slots_ff & ~head) == '0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign bank_free = ~rsp_valid | (pop & rsp_last);

   always_comb begin
      head_idx = 2'd0;
      for (int s = hpm_pkg::MAX_OUT - 1; s >= 0; s--) begin
         if (slots_ff[s]) begin
            head_idx = 2'(s);
         end
      end
   end

   always_comb begin
      slots_in = slots_ff;
      if (res_load) begin
         slots_in = res.slots;
      end else if (pop) begin
         slots_in = slots_ff & ~head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
      end else begin
         slots_ff <= slots_in;
      end
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign kind = res_ff.kinds[head_idx];

   always_comb begin
      rsp_kind             = kind;
      rsp_begin_time       = 64'd0;
      rsp_at_time          = res_ff.at_time;
      rsp_cycles           = 32'd0;
      rsp_lane             = 2'd0;
      rsp_open_at_end      = 1'b0;
      rsp_sample_count     = 32'd0;
      rsp_transfer_count   = 32'd0;
      rsp_ready_only_count = 32'd0;
      rsp_violation_count  = 32'd0;
      rsp_finding_count    = 32'd0;
      case (kind)
         hpm_pkg::KIND_READY_ONLY: ;
         hpm_pkg::KIND_DATA_CHANGED: begin
            rsp_begin_time = res_ff.begin_time;
            rsp_lane       = head_idx;
         end
         hpm_pkg::KIND_LONG_STALL: begin
            rsp_begin_time  = res_ff.begin_time;
            rsp_cycles      = res_ff.stall_len;
            rsp_open_at_end = res_ff.open_at_end;
         end
         hpm_pkg::KIND_SUMMARY: begin
            rsp_cycles           = res_ff.longest;
            rsp_sample_count     = res_ff.samples_total;
            rsp_transfer_count   = res_ff.transfer_count;
            rsp_ready_only_count = res_ff.ready_only_count;
            rsp_violation_count  = res_ff.violation_count;
            rsp_finding_count    = res_ff.findings_total;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- dv/tb_handshake_protocol_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_handshake_protocol_monitor - self-checking bench for the protocol monitor
// Feeds clock-sample and window-end beats through the req_ channel, programs
// the registers over the APB-style port and checks every rsp_ beat against
// an in-bench model of the monitor, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_handshake_protocol_monitor;

   // codes for handshake samples that are neither true nor false
   localparam logic [1:0] HS_UNKNOWN_X = 2'd2;
   localparam logic [1:0] HS_UNKNOWN_Z = 2'd3;

   localparam int SETTLE_CYCLES = 8;     // margin for the result latency
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 2000;  // cycles without any accepted beat or register access

   // one result beat as the monitor reports it
   typedef struct {
      hpm_pkg::kind_type kind;
      logic [63:0]       begin_time;
      logic [63:0]       at_time;
      logic [31:0]       cycles;
      logic [1:0]        lane;
      logic              open_at_end;
      logic              last;
      logic [31:0]       samples_total;
      logic [31:0]       transfer_count;
      logic [31:0]       ready_only_count;
      logic [31:0]       violation_count;
      logic [31:0]       findings_total;
   } finding_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // configuration port
   logic                       psel    = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite  = 1'b0;
   logic [hpm_pkg::ADDR_W-1:0] paddr   = '0;
   logic [31:0]                pwdata  = '0;
   logic [31:0]                prdata;
   logic                       pready;

   // input channel
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_op          = hpm_pkg::OP_SAMPLE;
   logic [63:0] req_sample_time = '0;
   logic [1:0]  req_valid_state = hpm_pkg::HS_FALSE;
   logic [1:0]  req_ready_state = hpm_pkg::HS_FALSE;
   logic [63:0] req_lane0       = '0;
   logic [63:0] req_lane1       = '0;
   logic [63:0] req_lane2       = '0;
   logic [63:0] req_lane3       = '0;

   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [63:0] rsp_begin_time;
   logic [63:0] rsp_at_time;
   logic [31:0] rsp_cycles;
   logic [1:0]  rsp_lane;
   logic        rsp_open_at_end;
   logic        rsp_last;
   logic [31:0] rsp_sample_count;
   logic [31:0] rsp_transfer_count;
   logic [31:0] rsp_ready_only_count;
   logic [31:0] rsp_violation_count;
   logic [31:0] rsp_finding_count;

   handshake_protocol_monitor u_dut (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_sample_time      (req_sample_time),
      .req_valid_state      (req_valid_state),
      .req_ready_state      (req_ready_state),
      .req_lane0            (req_lane0),
      .req_lane1            (req_lane1),
      .req_lane2            (req_lane2),
      .req_lane3            (req_lane3),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_begin_time       (rsp_begin_time),
      .rsp_at_time          (rsp_at_time),
      .rsp_cycles           (rsp_cycles),
      .rsp_lane             (rsp_lane),
      .rsp_open_at_end      (rsp_open_at_end),
      .rsp_last             (rsp_last),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_transfer_count   (rsp_transfer_count),
      .rsp_ready_only_count (rsp_ready_only_count),
      .rsp_violation_count  (rsp_violation_count),
      .rsp_finding_count    (rsp_finding_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Monitor model: register copies, window state and expected findings
   // ------------------------------------------------------------------------
   logic [15:0]        cfg_max_wait      = hpm_pkg::MAX_WAIT_RST;
   logic               cfg_check_data    = hpm_pkg::CHECK_DATA_RST;
   logic [16:0]        cfg_finding_limit = hpm_pkg::FINDING_LIMIT_RST;
   logic [2:0]         cfg_data_lanes    = hpm_pkg::DATA_LANES_RST;

   logic               win_in_stall;
   logic [31:0]        win_stall_len;
   logic [63:0]        win_stall_start;
   logic [63:0]        win_held_lanes [hpm_pkg::LANES];
   logic [31:0]        win_samples;
   logic [31:0]        win_transfers;
   logic [31:0]        win_longest;
   logic [31:0]        win_ready_only;
   logic [31:0]        win_violations;
   logic [31:0]        win_findings;

   finding_type        beat_findings[$];     // findings of the beat being modeled
   finding_type        pending_findings[$];  // findings still owed by the monitor

   int                 mismatch_count = 0;
   logic               idling_on = 1'b1;
   logic [63:0]        now_time = '0;

   // holdoff request from the test sequence, counted out by the receiver
   int                 hold_token = 0;
   int                 hold_seen  = 0;
   int                 hold_left  = 0;
   int                 rsp_burst  = 0;
   int                 quiet_cycles = 0;

   function automatic logic [31:0] count_up(input logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void clear_window();
      win_in_stall    = 1'b0;
      win_stall_len   = '0;
      win_stall_start = '0;
      for (int i = 0; i < hpm_pkg::LANES; i++) win_held_lanes[i] = '0;
      win_samples     = '0;
      win_transfers   = '0;
      win_longest     = '0;
      win_ready_only  = '0;
      win_violations  = '0;
      win_findings    = '0;
   endfunction

   function automatic void add_result(input hpm_pkg::kind_type kind,
                                      input logic [63:0] b_time,
                                      input logic [63:0] a_time, input logic [31:0] cyc,
                                      input logic [1:0] lane, input logic open_end);
      finding_type f;
      if (beat_findings.size() >= hpm_pkg::MAX_OUT) return;
      f = '{kind: kind, begin_time: b_time, at_time: a_time, cycles: cyc, lane: lane,
            open_at_end: open_end, default: '0};
      beat_findings.insert(beat_findings.size(), f);
   endfunction

   // count every finding, emit only while under the window's limit
   function automatic void raise_finding(input hpm_pkg::kind_type kind,
                                         input logic [63:0] b_time,
                                         input logic [63:0] a_time, input logic [31:0] cyc,
                                         input logic [1:0] lane, input logic open_end);
      logic shown;
      shown = cfg_finding_limit[16] || (win_findings < {16'd0, cfg_finding_limit[15:0]});
      win_findings = count_up(win_findings);
      if (shown) add_result(kind, b_time, a_time, cyc, lane, open_end);
   endfunction

   function automatic void close_stall(input logic [63:0] t, input logic open_end);
      if (win_stall_len > win_longest) win_longest = win_stall_len;
      if (win_stall_len > {16'd0, cfg_max_wait})
         raise_finding(hpm_pkg::KIND_LONG_STALL, win_stall_start, t, win_stall_len, 2'd0,
                       open_end);
   endfunction

   // work out the findings one accepted beat causes and queue them up
   function automatic void predict_findings(input hpm_pkg::item_type it);
      logic        v_true, v_false, r_true, r_false;
      int          used;
      finding_type summary;
      beat_findings.delete();
      if (it.op == hpm_pkg::OP_END) begin
         if (win_in_stall) close_stall(it.stamp, 1'b1);
         if (beat_findings.size() < hpm_pkg::MAX_OUT) begin
            summary = '{kind: hpm_pkg::KIND_SUMMARY, at_time: it.stamp, cycles: win_longest,
                        samples_total: win_samples, transfer_count: win_transfers,
                        ready_only_count: win_ready_only, violation_count: win_violations,
                        findings_total: win_findings, default: '0};
            beat_findings.insert(beat_findings.size(), summary);
         end
         clear_window();
      end else begin
         v_true  = it.valid_state == hpm_pkg::HS_TRUE;
         v_false = it.valid_state == hpm_pkg::HS_FALSE;
         r_true  = it.ready_state == hpm_pkg::HS_TRUE;
         r_false = it.ready_state == hpm_pkg::HS_FALSE;
         win_samples = count_up(win_samples);
         if (v_true && r_true) win_transfers = count_up(win_transfers);
         if (r_true && v_false) begin
            win_ready_only = count_up(win_ready_only);
            raise_finding(hpm_pkg::KIND_READY_ONLY, '0, it.stamp, '0, 2'd0, 1'b0);
         end
         if (v_true && r_false) begin
            win_stall_len = count_up(win_stall_len);
            if (!win_in_stall) begin
               win_in_stall    = 1'b1;
               win_stall_start = it.stamp;
               for (int i = 0; i < hpm_pkg::LANES && i < hpm_pkg::INPUT_LANES; i++)
                  win_held_lanes[i] = it.lanes[i];
            end else if (cfg_check_data) begin
               // lanes beyond what the block holds or carries are clamped off
               used = int'(cfg_data_lanes);
               if (used > hpm_pkg::LANES) used = hpm_pkg::LANES;
               if (used > hpm_pkg::INPUT_LANES) used = hpm_pkg::INPUT_LANES;
               for (int i = 0; i < used; i++) begin
                  if (((it.lanes[i] ^ win_held_lanes[i]) & hpm_pkg::LANE_MASK) != '0) begin
                     win_violations = count_up(win_violations);
                     raise_finding(hpm_pkg::KIND_DATA_CHANGED, win_stall_start, it.stamp,
                                   '0, i[1:0], 1'b0);
                  end
               end
            end
         end else if (win_in_stall) begin
            close_stall(it.stamp, 1'b0);
            win_in_stall  = 1'b0;
            win_stall_len = '0;
         end
      end
      if (beat_findings.size() > 0) beat_findings[$].last = 1'b1;
      foreach (beat_findings[i])
         pending_findings.insert(pending_findings.size(), beat_findings[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, long hold-off, field-by-field check
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result_beat();
      finding_type want;
      if (pending_findings.size() == 0) begin
         $error("result beat with no finding expected: kind %0d at %0h", rsp_kind,
                rsp_at_time);
         mismatch_count++;
         return;
      end
      want = pending_findings.pop_front();
      check_field("rsp_kind", want.kind, rsp_kind);
      check_field("rsp_begin_time", want.begin_time, rsp_begin_time);
      check_field("rsp_at_time", want.at_time, rsp_at_time);
      check_field("rsp_cycles", want.cycles, rsp_cycles);
      check_field("rsp_lane", want.lane, rsp_lane);
      check_field("rsp_open_at_end", want.open_at_end, rsp_open_at_end);
      check_field("rsp_last", want.last, rsp_last);
      check_field("rsp_sample_count", want.samples_total, rsp_sample_count);
      check_field("rsp_transfer_count", want.transfer_count, rsp_transfer_count);
      check_field("rsp_ready_only_count", want.ready_only_count, rsp_ready_only_count);
      check_field("rsp_violation_count", want.violation_count, rsp_violation_count);
      check_field("rsp_finding_count", want.findings_total, rsp_finding_count);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_burst = 0;
      end else begin
         // sample the handshake as it stood before this edge
         if (rsp_valid && !rsp_stall) check_result_beat();
         // pick up a hold-off request and count it out here
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_burst > 0) begin
            rsp_burst--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_burst = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: end the run if no beat of any kind moves and no register access happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Input side and register access
   // ------------------------------------------------------------------------

   // offer one beat, hold it until taken, then model it
   task automatic offer_beat(input hpm_pkg::item_type it);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_sample_time <= it.stamp;
      req_valid_state <= it.valid_state;
      req_ready_state <= it.ready_state;
      req_lane0       <= it.lanes[0];
      req_lane1       <= it.lanes[1];
      req_lane2       <= it.lanes[2];
      req_lane3       <= it.lanes[3];
      do @(posedge clock); while (req_stall);
      predict_findings(it);
   endtask

   function automatic hpm_pkg::item_type sample_beat(
         input logic [1:0] v, input logic [1:0] r, input logic [63:0] t,
         input logic [hpm_pkg::INPUT_LANES-1:0][63:0] ln);
      hpm_pkg::item_type it;
      it.op          = hpm_pkg::OP_SAMPLE;
      it.stamp       = t;
      it.valid_state = v;
      it.ready_state = r;
      it.lanes       = ln;
      return it;
   endfunction

   // window end; the handshake and lane fields carry noise the block ignores
   function automatic hpm_pkg::item_type end_beat(input logic [63:0] t);
      hpm_pkg::item_type it;
      it.op          = hpm_pkg::OP_END;
      it.stamp       = t;
      it.valid_state = 2'($urandom_range(0, 3));
      it.ready_state = 2'($urandom_range(0, 3));
      for (int i = 0; i < hpm_pkg::INPUT_LANES; i++) it.lanes[i] = rand64();
      return it;
   endfunction

   function automatic logic [63:0] next_time();
      if ($urandom_range(0, 15) == 0) now_time = rand64();
      else now_time = now_time + 64'($urandom_range(1, 20));
      return now_time;
   endfunction

   // drop valid, wait out every owed finding plus the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_findings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         hpm_pkg::REG_MAX_WAIT:      cfg_max_wait      = value[15:0];
         hpm_pkg::REG_CHECK_DATA:    cfg_check_data    = value[0];
         hpm_pkg::REG_FINDING_LIMIT: cfg_finding_limit = value[16:0];
         hpm_pkg::REG_DATA_LANES:    cfg_data_lanes    = value[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] mw, input logic cd,
                                 input logic [16:0] fl, input logic [2:0] dl);
      settle();
      csr_write(hpm_pkg::REG_MAX_WAIT, {16'd0, mw});
      csr_write(hpm_pkg::REG_CHECK_DATA, {31'd0, cd});
      csr_write(hpm_pkg::REG_FINDING_LIMIT, {15'd0, fl});
      csr_write(hpm_pkg::REG_DATA_LANES, {29'd0, dl});
   endtask

   // random windows: mostly stall runs, transfers and ready-only cycles, with
   // some unknown handshakes and fully random noise mixed in
   task automatic run_windows(input int budget);
      int                                      sent;
      int                                      body;
      int                                      run;
      int                                      k;
      int                                      b;
      logic [hpm_pkg::INPUT_LANES-1:0][63:0]   base;
      logic [hpm_pkg::INPUT_LANES-1:0][63:0]   ln;
      sent = 0;
      while (sent < budget) begin
         body = $urandom_range(0, 14);
         while (body > 0) begin
            for (k = 0; k < hpm_pkg::INPUT_LANES; k++) ln[k] = rand64();
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  base = ln;
                  run  = $urandom_range(1, 10);
                  if (run > body) run = body;
                  repeat (run) begin
                     ln = base;
                     if ($urandom_range(0, 3) == 0) begin
                        k = $urandom_range(0, hpm_pkg::INPUT_LANES - 1);
                        b = $urandom_range(0, 63);
                        ln[k][b] = ~ln[k][b];
                     end else if ($urandom_range(0, 9) == 0) begin
                        for (k = 0; k < hpm_pkg::INPUT_LANES; k++) ln[k] = rand64();
                     end
                     offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE,
                                            next_time(), ln));
                     body--;
                     sent++;
                  end
               end
               4, 5: begin
                  offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_TRUE, next_time(),
                                         ln));
                  body--;
                  sent++;
               end
               6: begin
                  offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, next_time(),
                                         ln));
                  body--;
                  sent++;
               end
               7: begin
                  offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_FALSE, next_time(),
                                         ln));
                  body--;
                  sent++;
               end
               default: begin
                  offer_beat(sample_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                         next_time(), ln));
                  body--;
                  sent++;
               end
            endcase
         end
         offer_beat(end_beat(next_time()));
         sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // each handshake code, all lanes changed, stall ends: x valid, ready-only, transfer, window end
   task automatic test_directed_cases();
      logic [hpm_pkg::INPUT_LANES-1:0][63:0] zero_l;
      logic [hpm_pkg::INPUT_LANES-1:0][63:0] base;
      logic [hpm_pkg::INPUT_LANES-1:0][63:0] ln;
      zero_l = '0;
      base   = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd0,
                64'hFFFF_FFFF_FFFF_FFFF};
      apply_settings(16'd0, 1'b1, 17'h1FFFF, 3'd4);
      // empty window still reports an all-zero summary
      offer_beat(end_beat(64'd0));
      offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, 64'd1, zero_l));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_TRUE, 64'd2, zero_l));
      // unknown valid or ready: no transfer, no stall, no ready-only
      offer_beat(sample_beat(HS_UNKNOWN_X, hpm_pkg::HS_TRUE, 64'd3, zero_l));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, HS_UNKNOWN_Z, 64'd4, zero_l));
      offer_beat(sample_beat(HS_UNKNOWN_Z, HS_UNKNOWN_X, 64'd5, zero_l));
      offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_FALSE, 64'd6, zero_l));
      // stall with a value bit and an x/z mark bit changing, then all lanes
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'd7, base));
      ln = base;
      ln[0][0]  = ~ln[0][0];
      ln[3][63] = ~ln[3][63];
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'd8, ln));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'd9, ~base));
      // unknown valid ends the stall: long stall finding
      offer_beat(sample_beat(HS_UNKNOWN_X, hpm_pkg::HS_FALSE, 64'd10, base));
      // ready-only ends a stall: ready-only finding, then long stall
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'd11, base));
      offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, 64'd12, base));
      // a transfer ends a stall too
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'd13, zero_l));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_TRUE, 64'd14, zero_l));
      // stall still open at window end, at the largest time
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'hFFFF_FFFF_FFFF_FFFF,
                             ~zero_l));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, 64'hFFFF_FFFF_FFFF_FFFF,
                             ~zero_l));
      offer_beat(end_beat(64'hFFFF_FFFF_FFFF_FFFF));
   endtask

   // suppressed findings, clamped lane count and the widest register values
   task automatic test_finding_limit();
      logic [hpm_pkg::INPUT_LANES-1:0][63:0] base;
      base = {rand64(), rand64(), rand64(), rand64()};
      // limit of zero: everything counted, nothing but the summary shown
      apply_settings(16'hFFFF, 1'b0, 17'd0, 3'd7);
      repeat (3) offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, next_time(),
                                        base));
      offer_beat(end_beat(next_time()));
      // limit of two with lane count above four
      apply_settings(16'd2, 1'b1, 17'd2, 3'd7);
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, next_time(), base));
      repeat (3) offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, next_time(),
                                        ~base));
      offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, next_time(), base));
      offer_beat(end_beat(next_time()));
      // largest positive limit, one lane checked, stall below the wait limit
      apply_settings(16'hFFFF, 1'b1, 17'h0FFFF, 3'd1);
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, next_time(), base));
      offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, next_time(), ~base));
      offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_FALSE, next_time(), base));
      offer_beat(end_beat(next_time()));
   endtask

   // random windows under a series of register settings
   task automatic test_random_settings();
      apply_settings(16'd3, 1'b1, 17'h1FFFF, 3'd4);
      run_windows(40);
      apply_settings(16'd0, 1'b1, 17'd3, 3'd2);
      run_windows(40);
      apply_settings(16'hFFFF, 1'b0, 17'h0FFFF, 3'd7);
      run_windows(40);
      // most negative limit is still unlimited
      apply_settings(16'd1, 1'b1, 17'h10000, 3'd3);
      run_windows(40);
      apply_settings(16'($urandom_range(0, 10)), 1'($urandom_range(0, 1)),
                     17'($urandom_range(0, 8)), 3'($urandom_range(0, 7)));
      run_windows(40);
   endtask

   // hold the result side off while the sender keeps offering finding beats,
   // so the result bank fills and the input stalls
   task automatic test_receiver_holdoff();
      logic [hpm_pkg::INPUT_LANES-1:0][63:0] ln;
      apply_settings(16'd1, 1'b1, 17'h1FFFF, 3'd4);
      idling_on = 1'b0;
      hold_token <= hold_token + 1;
      repeat (20) begin
         ln = {rand64(), rand64(), rand64(), rand64()};
         offer_beat(sample_beat(hpm_pkg::HS_FALSE, hpm_pkg::HS_TRUE, next_time(), ln));
         offer_beat(sample_beat(hpm_pkg::HS_TRUE, hpm_pkg::HS_FALSE, next_time(), ln));
      end
      offer_beat(end_beat(next_time()));
      idling_on = 1'b1;
   endtask

   // last stretch: full rate on both sides
   task automatic test_steady_stream();
      apply_settings(16'd4, 1'b1, 17'd40, 3'd4);
      idling_on = 1'b0;
      run_windows(40);
   endtask

   initial begin
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_finding_limit();
      test_random_settings();
      test_receiver_holdoff();
      test_steady_stream();

      // drain: every owed finding back, then a margin for strays
      settle();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
